@@ sv/tpop_pkg.sv @@
// ----------------------------------------------------------------------------
// Time-phi occupancy prefilter package
// Shared sizes, action and register codes, state encoding and the configuration, command and status bundles.
// ----------------------------------------------------------------------------
package tpop_pkg;

   localparam int MAX_TIME_BINS = 128;
   localparam int MAX_PHI_BINS  = 64;
   localparam int COUNT_BITS    = 8;

   localparam int TIME_BITS = $clog2(MAX_TIME_BINS);
   localparam int PHI_BITS  = (MAX_PHI_BINS > 1) ? $clog2(MAX_PHI_BINS) : 1;
   localparam int NUM_CELLS = MAX_TIME_BINS * MAX_PHI_BINS;
   localparam int CELL_BITS = $clog2(NUM_CELLS);
   localparam int SUM_BITS  = COUNT_BITS + 4;

   localparam logic [1:0] ACT_CLEAR    = 2'd0;
   localparam logic [1:0] ACT_ACCUM    = 2'd1;
   localparam logic [1:0] ACT_BUILD    = 2'd2;
   localparam logic [1:0] ACT_CLASSIFY = 2'd3;

   localparam logic [2:0] REG_TIME_SCALE = 3'd0;
   localparam logic [2:0] REG_PHI_SCALE  = 3'd1;
   localparam logic [2:0] REG_NUM_TIME   = 3'd2;
   localparam logic [2:0] REG_NUM_PHI    = 3'd3;
   localparam logic [2:0] REG_MIN_CELL   = 3'd4;
   localparam logic [2:0] REG_MIN_SUM    = 3'd5;
   localparam logic [2:0] REG_SIG_MASK   = 3'd6;
   localparam logic [2:0] REG_BKG_MASK   = 3'd7;

   typedef enum logic [3:0] {
      ST_CLR_ALL, ST_IDLE, ST_BIN, ST_LOOKUP, ST_RESPOND,
      ST_B_CLR, ST_B_READ, ST_B_WAIT, ST_B_EVAL, ST_B_MARK, ST_B_NEXT
   } state_type;

   typedef struct packed {
      logic [15:0] time_scale;
      logic [15:0] phi_scale;
      logic [7:0]  num_time_bins;
      logic [6:0]  num_phi_bins;
      logic [7:0]  min_cell_hits;
      logic [11:0] min_sum_hits;
      logic [31:0] signal_mask;
      logic [31:0] background_mask;
   } cfg_type;

   typedef struct packed {
      logic load;
      logic bin;
      logic lookup;
      logic respond;
      logic clr_counts;
      logic clr_blind;
      logic scan_start;
      logic scan_next;
      logic rewind;
      logic nb_read;
      logic nb_mark;
   } cmd_type;

   typedef struct packed {
      logic sweep_last;
      logic grid_ok;
      logic scan_last;
      logic nb_last;
      logic blind_hit;
   } status_type;

endpackage

@@ sv/time_phi_occupancy_prefilter.sv @@
// ----------------------------------------------------------------------------
// Time-phi occupancy prefilter
// Bins hits into a time-by-phi grid that wraps in phi, builds a blind map and
// classifies hits against it.
// ----------------------------------------------------------------------------
// Channel   Signals                                  Transfer
// req       start, busy, req_action, req_hit_*       start high, busy low
// rsp       rsp_strobe, rsp_blinded, rsp_cell_index  one cycle per strobe
// csr       csr_valid, csr_ready, csr_index, ..      valid and ready high
//
// Accumulate and classify step through the binning multiply, the cell index,
// the memory read and a last step, which for accumulate is the read-modify-
// write of the count memory. Clear sweeps both memories one entry a cycle;
// after reset the same sweep runs with busy high. Build sweeps the blind map
// clear, then for each interior cell reads its nine neighbours through the
// single count read port and, when the cell blinds its neighbourhood, marks all nine.
// The receiver cannot stall: results appear the cycle after the last step.
// ----------------------------------------------------------------------------
module time_phi_occupancy_prefilter import tpop_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [1:0]           req_action,
   input  logic [15:0]          req_hit_time,
   input  logic signed [15:0]   req_hit_phi,
   input  logic [31:0]          req_hit_flags,
   output logic                 rsp_strobe,
   output logic                 rsp_blinded,
   output logic [CELL_BITS-1:0] rsp_cell_index,
   output logic                 rsp_range_error,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [2:0]           csr_index,
   input  logic [31:0]          csr_wdata
);

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;
   logic       ctl_busy;

   assign csr_ready = 1'b1;
   assign busy      = ctl_busy;

   tpop_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   tpop_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .action (req_action),
      .status (status),
      .cmd    (cmd),
      .busy   (ctl_busy)
   );

   tpop_datapath u_dp (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .cmd             (cmd),
      .req_action      (req_action),
      .req_hit_time    (req_hit_time),
      .req_hit_phi     (req_hit_phi),
      .req_hit_flags   (req_hit_flags),
      .status          (status),
      .rsp_strobe      (rsp_strobe),
      .rsp_blinded     (rsp_blinded),
      .rsp_cell_index  (rsp_cell_index),
      .rsp_range_error (rsp_range_error)
   );

   // A result only follows a transaction that was in progress.
   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result without a transaction in progress");

   // An out-of-range hit reports cell zero and is never blinded.
   a_range_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_range_error) |-> (rsp_cell_index == '0 && !rsp_blinded))
      else $error("out-of-range result with cell or blind set");

   // The clearing sweep holds the block busy straight after reset.
   a_busy_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> busy)
      else $error("block idle straight after reset");

endmodule

@@ sv/tpop_csr.sv @@
// ----------------------------------------------------------------------------
// Time-phi occupancy prefilter configuration registers
// Holds the eight configuration registers written over the CSR channel.
// ----------------------------------------------------------------------------
module tpop_csr import tpop_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata,
   output cfg_type     cfg
);

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_TIME_SCALE: cfg_in.time_scale      = csr_wdata[15:0];
            REG_PHI_SCALE:  cfg_in.phi_scale       = csr_wdata[15:0];
            REG_NUM_TIME:   cfg_in.num_time_bins   = csr_wdata[7:0];
            REG_NUM_PHI:    cfg_in.num_phi_bins    = csr_wdata[6:0];
            REG_MIN_CELL:   cfg_in.min_cell_hits   = csr_wdata[7:0];
            REG_MIN_SUM:    cfg_in.min_sum_hits    = csr_wdata[11:0];
            REG_SIG_MASK:   cfg_in.signal_mask     = csr_wdata;
            REG_BKG_MASK:   cfg_in.background_mask = csr_wdata;
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{time_scale: 16'd205, phi_scale: 16'd63, num_time_bins: 8'd128,
                     num_phi_bins: 7'd64, min_cell_hits: 8'd3, min_sum_hits: 12'd6,
                     signal_mask: 32'd0, background_mask: 32'd0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ sv/tpop_ctrl.sv @@
// ----------------------------------------------------------------------------
// Time-phi occupancy prefilter controller
// Sequences clearing, hit binning, lookups and the blind map build.
// ----------------------------------------------------------------------------
module tpop_ctrl import tpop_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic [1:0] action,
   input  status_type status,
   output cmd_type    cmd,
   output logic       busy
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLR_ALL;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_CLR_ALL: begin
            cmd.clr_counts = 1'b1;
            cmd.clr_blind  = 1'b1;
            if (status.sweep_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               case (action)
                  ACT_CLEAR:    state_in = ST_CLR_ALL;
                  ACT_BUILD:    state_in = ST_B_CLR;
                  ACT_ACCUM:    state_in = ST_BIN;
                  ACT_CLASSIFY: state_in = ST_BIN;
                  default:      state_in = ST_IDLE;
               endcase
            end
         end
         ST_BIN: begin
            cmd.bin  = 1'b1;
            state_in = ST_LOOKUP;
         end
         ST_LOOKUP: begin
            cmd.lookup = 1'b1;
            state_in   = ST_RESPOND;
         end
         ST_RESPOND: begin
            cmd.respond = 1'b1;
            state_in    = ST_IDLE;
         end
         ST_B_CLR: begin
            cmd.clr_blind = 1'b1;
            if (status.sweep_last) begin
               if (status.grid_ok) begin
                  cmd.scan_start = 1'b1;
                  state_in       = ST_B_READ;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_B_READ: begin
            cmd.nb_read = 1'b1;
            if (status.nb_last) state_in = ST_B_WAIT;
         end
         ST_B_WAIT: begin
            state_in = ST_B_EVAL;
         end
         ST_B_EVAL: begin
            cmd.rewind = 1'b1;
            state_in   = status.blind_hit ? ST_B_MARK : ST_B_NEXT;
         end
         ST_B_MARK: begin
            cmd.nb_mark = 1'b1;
            if (status.nb_last) state_in = ST_B_NEXT;
         end
         ST_B_NEXT: begin
            if (status.scan_last) begin
               state_in = ST_IDLE;
            end else begin
               cmd.scan_next = 1'b1;
               state_in      = ST_B_READ;
            end
         end
         default: state_in = ST_CLR_ALL;
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

@@ sv/tpop_datapath.sv @@
// ----------------------------------------------------------------------------
// Time-phi occupancy prefilter datapath
// Bin arithmetic, the count and blind memories, the build scan and results.
// ----------------------------------------------------------------------------
module tpop_datapath import tpop_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  cfg_type              cfg,
   input  cmd_type              cmd,
   input  logic [1:0]           req_action,
   input  logic [15:0]          req_hit_time,
   input  logic signed [15:0]   req_hit_phi,
   input  logic [31:0]          req_hit_flags,
   output status_type           status,
   output logic                 rsp_strobe,
   output logic                 rsp_blinded,
   output logic [CELL_BITS-1:0] rsp_cell_index,
   output logic                 rsp_range_error
);

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   logic [COUNT_BITS-1:0] count_mem [NUM_CELLS];
   logic                  blind_mem [NUM_CELLS];

   logic [7:0]           nt_use;
   logic [6:0]           np_use;
   logic [1:0]           act_ff;
   logic                 pass_ff;
   logic [31:0]          tprod_ff, pprod_ff;
   logic [CELL_BITS-1:0] cell_ff, cell_in;
   logic                 ok_ff, ok_in;
   logic [CELL_BITS-1:0] sw_ff;
   logic [COUNT_BITS-1:0] cnt_rd_ff;
   logic                 blind_rd_ff;
   logic [PHI_BITS-1:0]  p_ff, row_dn, row_up, row;
   logic [TIME_BITS-1:0] t_ff, col;
   logic [1:0]           dr_ff, dc_ff;
   logic                 acc_vld_ff, ctr_vld_ff;
   logic [SUM_BITS-1:0]  sum_ff;
   logic [COUNT_BITS-1:0] own_ff;
   logic [CELL_BITS-1:0] nb_addr, cnt_raddr;
   logic [15:0]          tb, pb;
   logic                 rsp_strobe_ff, rsp_blinded_ff, rsp_err_ff;
   logic [CELL_BITS-1:0] rsp_cell_ff;

   assign nt_use = (cfg.num_time_bins > 8'(MAX_TIME_BINS)) ? 8'(MAX_TIME_BINS)
                                                           : cfg.num_time_bins;
   assign np_use = (cfg.num_phi_bins > 7'(MAX_PHI_BINS)) ? 7'(MAX_PHI_BINS)
                                                         : cfg.num_phi_bins;

   assign tb = tprod_ff[31:16];
   assign pb = pprod_ff[31:16];

   always_comb begin
      ok_in   = (tb < {8'd0, nt_use}) && (pb < {9'd0, np_use});
      cell_in = '0;
      if (ok_in) begin
         cell_in = CELL_BITS'(tb[TIME_BITS-1:0])
                 + CELL_BITS'(pb[PHI_BITS-1:0] * nt_use);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         act_ff   <= req_action;
         pass_ff  <= ((req_hit_flags & cfg.signal_mask) == cfg.signal_mask)
                  && ((req_hit_flags & cfg.background_mask) == 32'd0);
         tprod_ff <= req_hit_time * cfg.time_scale;
         pprod_ff <= {~req_hit_phi[15], req_hit_phi[14:0]} * cfg.phi_scale;
      end
      if (cmd.bin) begin
         cell_ff <= cell_in;
         ok_ff   <= ok_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sw_ff <= '0;
      end else if (cmd.clr_counts || cmd.clr_blind) begin
         sw_ff <= sw_ff + 1'b1;
      end
   end

   assign row_dn = (p_ff == '0) ? PHI_BITS'(np_use - 7'd1) : p_ff - 1'b1;
   assign row_up = (7'(p_ff) + 7'd1 == np_use) ? '0 : p_ff + 1'b1;

   always_comb begin
      case (dr_ff)
         2'd0:    row = row_dn;
         2'd1:    row = p_ff;
         default: row = row_up;
      endcase
      col     = t_ff + TIME_BITS'(dc_ff) - 1'b1;
      nb_addr = CELL_BITS'(col) + CELL_BITS'(row * nt_use);
      cnt_raddr = cmd.nb_read ? nb_addr : cell_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_start) begin
         p_ff <= '0;
         t_ff <= TIME_BITS'(1);
      end else if (cmd.scan_next) begin
         if (8'(t_ff) == nt_use - 8'd2) begin
            t_ff <= TIME_BITS'(1);
            p_ff <= p_ff + 1'b1;
         end else begin
            t_ff <= t_ff + 1'b1;
         end
      end
      if (cmd.scan_start || cmd.scan_next || cmd.rewind) begin
         dr_ff <= 2'd0;
         dc_ff <= 2'd0;
      end else if (cmd.nb_read || cmd.nb_mark) begin
         if (dc_ff == 2'd2) begin
            dc_ff <= 2'd0;
            dr_ff <= dr_ff + 2'd1;
         end else begin
            dc_ff <= dc_ff + 2'd1;
         end
      end
      acc_vld_ff <= cmd.nb_read;
      ctr_vld_ff <= cmd.nb_read && dr_ff == 2'd1 && dc_ff == 2'd1;
      if (cmd.scan_start || cmd.scan_next || cmd.rewind) begin
         sum_ff <= '0;
      end else if (acc_vld_ff) begin
         sum_ff <= sum_ff + SUM_BITS'(cnt_rd_ff);
      end
      if (ctr_vld_ff) own_ff <= cnt_rd_ff;
   end

   always_ff @(posedge clock) begin
      cnt_rd_ff <= count_mem[cnt_raddr];
      if (cmd.clr_counts) begin
         count_mem[sw_ff] <= '0;
      end else if (cmd.respond && act_ff == ACT_ACCUM && ok_ff && pass_ff
                   && cnt_rd_ff != COUNT_MAX) begin
         count_mem[cell_ff] <= cnt_rd_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      blind_rd_ff <= blind_mem[cell_ff];
      if (cmd.clr_blind) begin
         blind_mem[sw_ff] <= 1'b0;
      end else if (cmd.nb_mark) begin
         blind_mem[nb_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= cmd.respond;
      end
      if (cmd.respond) begin
         rsp_blinded_ff <= ok_ff && act_ff == ACT_CLASSIFY && blind_rd_ff;
         rsp_cell_ff    <= cell_ff;
         rsp_err_ff     <= !ok_ff;
      end
   end

   assign status.sweep_last = (sw_ff == CELL_BITS'(NUM_CELLS - 1));
   assign status.grid_ok    = (nt_use >= 8'd3) && (np_use != 7'd0);
   assign status.scan_last  = (8'(t_ff) == nt_use - 8'd2)
                           && (7'(p_ff) == np_use - 7'd1);
   assign status.nb_last    = (dr_ff == 2'd2) && (dc_ff == 2'd2);
   assign status.blind_hit  = (own_ff >= cfg.min_cell_hits)
                           || (sum_ff >= cfg.min_sum_hits);

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_blinded     = rsp_blinded_ff;
   assign rsp_cell_index  = rsp_cell_ff;
   assign rsp_range_error = rsp_err_ff;

endmodule

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// Testbench for the time-phi occupancy prefilter
// Drives clear, accumulate, build and classify commands, with register
// settings changed between phases, and checks every response against a
// predictor kept in the testbench.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
   import tpop_pkg::*;

   localparam int IDLE_LIMIT = 600000;

   typedef struct {
      logic                 blinded;
      logic [CELL_BITS-1:0] cell_idx;
      logic                 range_err;
   } hit_result_type;

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic [1:0]           req_action;
   logic [15:0]          req_hit_time;
   logic signed [15:0]   req_hit_phi;
   logic [31:0]          req_hit_flags;
   logic                 rsp_strobe;
   logic                 rsp_blinded;
   logic [CELL_BITS-1:0] rsp_cell_index;
   logic                 rsp_range_error;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [2:0]           csr_index;
   logic [31:0]          csr_wdata;

   logic [15:0] cfg_time_scale, cfg_phi_scale;
   logic [7:0]  cfg_num_time, cfg_min_cell;
   logic [6:0]  cfg_num_phi;
   logic [11:0] cfg_min_sum;
   logic [31:0] cfg_sig_mask, cfg_bkg_mask;

   logic [COUNT_BITS-1:0] occupancy[NUM_CELLS];
   logic                  blind_cells[NUM_CELLS];

   hit_result_type pending_hits[$];
   int  mismatch_count;
   int  items_sent;
   int  idle_cycles;
   bit  steady_sender;

   time_phi_occupancy_prefilter dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_action(req_action), .req_hit_time(req_hit_time),
      .req_hit_phi(req_hit_phi), .req_hit_flags(req_hit_flags),
      .rsp_strobe(rsp_strobe), .rsp_blinded(rsp_blinded),
      .rsp_cell_index(rsp_cell_index), .rsp_range_error(rsp_range_error),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   function automatic int used_time_bins();
      return (cfg_num_time > MAX_TIME_BINS) ? MAX_TIME_BINS : int'(cfg_num_time);
   endfunction

   function automatic int used_phi_bins();
      return (cfg_num_phi > MAX_PHI_BINS) ? MAX_PHI_BINS : int'(cfg_num_phi);
   endfunction

   function automatic bit find_cell(input logic [15:0] t_raw, input logic [15:0] p_raw,
                                    output int cell_no);
      int unsigned tb, pb;
      tb = (32'(t_raw) * 32'(cfg_time_scale)) >> 16;
      pb = (32'(p_raw ^ 16'h8000) * 32'(cfg_phi_scale)) >> 16;
      cell_no = 0;
      if (tb >= used_time_bins() || pb >= used_phi_bins()) return 1'b0;
      cell_no = tb + pb * used_time_bins();
      return 1'b1;
   endfunction

   task automatic clear_grid();
      for (int i = 0; i < NUM_CELLS; i++) begin
         occupancy[i] = '0;
         blind_cells[i] = 1'b0;
      end
   endtask

   task automatic build_blind_map();
      int nt, np, rc, ru, rd, own, sum;
      nt = used_time_bins();
      np = used_phi_bins();
      for (int i = 0; i < NUM_CELLS; i++) blind_cells[i] = 1'b0;
      if (nt < 3 || np == 0) return;
      for (int p = 0; p < np; p++) begin
         rc = p * nt;
         ru = ((p + 1) % np) * nt;
         rd = ((p + np - 1) % np) * nt;
         for (int t = 1; t + 1 < nt; t++) begin
            own = occupancy[rc + t];
            sum = 0;
            for (int d = -1; d <= 1; d++)
               sum += occupancy[rc + t + d] + occupancy[ru + t + d] + occupancy[rd + t + d];
            if (own >= cfg_min_cell || sum >= cfg_min_sum) begin
               for (int d = -1; d <= 1; d++) begin
                  blind_cells[rc + t + d] = 1'b1;
                  blind_cells[ru + t + d] = 1'b1;
                  blind_cells[rd + t + d] = 1'b1;
               end
            end
         end
      end
   endtask

   task automatic predict_command(input logic [1:0] act, input logic [15:0] t_raw,
                                  input logic [15:0] p_raw, input logic [31:0] flags);
      hit_result_type r;
      int  cell_no;
      bit  ok;
      case (act)
         ACT_CLEAR: clear_grid();
         ACT_BUILD: build_blind_map();
         default: begin
            ok = find_cell(t_raw, p_raw, cell_no);
            r.blinded = 1'b0;
            r.cell_idx = ok ? CELL_BITS'(cell_no) : '0;
            r.range_err = !ok;
            if (ok && act == ACT_ACCUM) begin
               if ((flags & cfg_sig_mask) == cfg_sig_mask && (flags & cfg_bkg_mask) == 0 &&
                   occupancy[cell_no] != {COUNT_BITS{1'b1}})
                  occupancy[cell_no] = occupancy[cell_no] + 1'b1;
            end else if (ok) begin
               r.blinded = blind_cells[cell_no];
            end
            pending_hits = {pending_hits, r};
         end
      endcase
   endtask

   // Responses cannot be stalled, so each strobe is checked as it arrives.
   always @(posedge clock) begin
      hit_result_type e;
      if (!reset && rsp_strobe) begin
         if (pending_hits.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("Unexpected response: cell %0d blinded %0b range %0b",
                        rsp_cell_index, rsp_blinded, rsp_range_error);
         end else begin
            e = pending_hits.pop_front();
            if (rsp_blinded !== e.blinded || rsp_cell_index !== e.cell_idx ||
                rsp_range_error !== e.range_err) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("Mismatch cell/blinded/range: exp %0d/%0b/%0b got %0d/%0b/%0b",
                           e.cell_idx, e.blinded, e.range_err,
                           rsp_cell_index, rsp_blinded, rsp_range_error);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAIL time_phi_occupancy_prefilter");
         $finish;
      end
   end

   task automatic send_command(input logic [1:0] act, input logic [15:0] t_raw,
                               input logic [15:0] p_raw, input logic [31:0] flags);
      int gap;
      gap = steady_sender ? 0 : $urandom_range(0, 5);
      @(negedge clock);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start <= 1'b1;
      req_action <= act;
      req_hit_time <= t_raw;
      req_hit_phi <= p_raw;
      req_hit_flags <= flags;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_command(act, t_raw, p_raw, flags);
      items_sent++;
   endtask

   // Holds the sender off until the block is idle and every response is in.
   task automatic drain_block();
      @(negedge clock);
      start <= 1'b0;
      @(posedge clock);
      while (busy || pending_hits.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
      drain_block();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         REG_TIME_SCALE: cfg_time_scale = value[15:0];
         REG_PHI_SCALE:  cfg_phi_scale = value[15:0];
         REG_NUM_TIME:   cfg_num_time = value[7:0];
         REG_NUM_PHI:    cfg_num_phi = value[6:0];
         REG_MIN_CELL:   cfg_min_cell = value[7:0];
         REG_MIN_SUM:    cfg_min_sum = value[11:0];
         REG_SIG_MASK:   cfg_sig_mask = value;
         REG_BKG_MASK:   cfg_bkg_mask = value;
         default:        ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_grid(input int ts, input int ps, input int nt, input int np,
                           input int min_cell, input int min_sum);
      write_reg(REG_TIME_SCALE, ts);
      write_reg(REG_PHI_SCALE, ps);
      write_reg(REG_NUM_TIME, nt);
      write_reg(REG_NUM_PHI, np);
      write_reg(REG_MIN_CELL, min_cell);
      write_reg(REG_MIN_SUM, min_sum);
   endtask

   // Raw time that mostly lands within one bin of the grid's time range.
   function automatic logic [15:0] pick_time();
      longint bound;
      if ($urandom_range(0, 9) == 0) return 16'($urandom);
      bound = ((longint'(used_time_bins()) + 1) * 65536) / (cfg_time_scale + 1);
      if (bound > 65535) bound = 65535;
      return 16'($urandom_range(0, int'(bound)));
   endfunction

   function automatic logic [15:0] pick_phi();
      longint bound;
      if ($urandom_range(0, 9) == 0) return 16'($urandom);
      bound = ((longint'(used_phi_bins()) + 1) * 65536) / (cfg_phi_scale + 1);
      if (bound > 65535) bound = 65535;
      return 16'($urandom_range(0, int'(bound))) ^ 16'h8000;
   endfunction

   function automatic logic [31:0] pick_flags();
      logic [31:0] f;
      f = $urandom;
      if ($urandom_range(0, 3) != 0) f = (f | cfg_sig_mask) & ~cfg_bkg_mask;
      return f;
   endfunction

   task automatic test_reset_defaults();
      steady_sender = 1'b1;
      send_command(ACT_ACCUM, 16'd0, 16'h8000, 32'd0);
      send_command(ACT_ACCUM, 16'hFFFF, 16'h7FFF, 32'hFFFF_FFFF);
      send_command(ACT_ACCUM, 16'd5000, 16'h7FFF, 32'd0);
      repeat (3) send_command(ACT_ACCUM, 16'd5000, 16'h0000, 32'h1234_5678);
      send_command(ACT_ACCUM, 16'd5400, 16'h0400, 32'd0);
      send_command(ACT_CLASSIFY, 16'd5000, 16'h0000, 32'd0);
      send_command(ACT_BUILD, 16'd0, 16'd0, 32'd0);
      send_command(ACT_CLASSIFY, 16'd5000, 16'h0000, 32'd0);
      send_command(ACT_CLASSIFY, 16'd5400, 16'h0400, 32'd0);
      send_command(ACT_CLASSIFY, 16'd0, 16'h8000, 32'd0);
      send_command(ACT_CLASSIFY, 16'hFFFF, 16'h8000, 32'd0);
      send_command(ACT_CLEAR, 16'd0, 16'd0, 32'd0);
      send_command(ACT_CLASSIFY, 16'd5000, 16'h0000, 32'd0);
   endtask

   task automatic test_masks();
      set_grid(4096, 4096, 16, 16, 1, 4095);
      write_reg(REG_SIG_MASK, 32'hA000_0005);
      write_reg(REG_BKG_MASK, 32'h0000_0100);
      steady_sender = 1'b0;
      send_command(ACT_ACCUM, 16'h0030, 16'h8000, 32'hA000_0005);
      send_command(ACT_ACCUM, 16'h0040, 16'h8000, 32'hA000_0004);
      send_command(ACT_ACCUM, 16'h0050, 16'h8000, 32'hA000_0105);
      send_command(ACT_ACCUM, 16'hFFFF, 16'h8000, 32'hA000_0105);
      send_command(ACT_BUILD, 16'd0, 16'd0, 32'd0);
      send_command(ACT_CLASSIFY, 16'h0030, 16'h8000, 32'd0);
      send_command(ACT_CLASSIFY, 16'h0040, 16'h9000, 32'd0);
      send_command(ACT_CLASSIFY, 16'h0050, 16'h8000, 32'hFFFF_FFFF);
      write_reg(REG_SIG_MASK, 32'hFFFF_FFFF);
      write_reg(REG_BKG_MASK, 32'hFFFF_FFFF);
      send_command(ACT_ACCUM, 16'h0030, 16'h8000, 32'hFFFF_FFFF);
      write_reg(REG_BKG_MASK, 32'd0);
      send_command(ACT_ACCUM, 16'h0030, 16'h8000, 32'hFFFF_FFFF);
      write_reg(REG_SIG_MASK, 32'd0);
   endtask

   task automatic test_count_saturation();
      set_grid(65535, 65535, 3, 1, 255, 4095);
      send_command(ACT_CLEAR, 16'd0, 16'd0, 32'd0);
      repeat (300) send_command(ACT_ACCUM, 16'd2, 16'h8000, $urandom);
      send_command(ACT_BUILD, 16'd0, 16'd0, 32'd0);
      send_command(ACT_CLASSIFY, 16'd2, 16'h8000, 32'd0);
      send_command(ACT_CLASSIFY, 16'hFFFF, 16'h8000, 32'd0);
      write_reg(REG_MIN_CELL, 0);
      write_reg(REG_MIN_SUM, 0);
      send_command(ACT_BUILD, 16'd0, 16'd0, 32'd0);
      send_command(ACT_CLASSIFY, 16'h0000, 16'h8000, 32'd0);
   endtask

   task automatic test_tiny_grids();
      int nt_set[7] = '{0, 1, 2, 3, 4, 255, 129};
      int np_set[7] = '{0, 1, 2, 1, 2, 127, 65};
      for (int k = 0; k < 7; k++) begin
         set_grid((k == 2) ? 0 : $urandom_range(40000, 65535),
                  (k == 3) ? 0 : $urandom_range(20000, 65535),
                  nt_set[k], np_set[k], $urandom_range(1, 3), $urandom_range(2, 9));
         send_command(ACT_CLEAR, 16'd0, 16'd0, 32'd0);
         repeat (12) send_command(ACT_ACCUM, pick_time(), pick_phi(), $urandom);
         send_command(ACT_BUILD, 16'd0, 16'd0, 32'd0);
         repeat (8) send_command(ACT_CLASSIFY, pick_time(), pick_phi(), $urandom);
      end
   endtask

   task automatic test_random_events();
      logic [15:0] hot_t[3], hot_p[3];
      int n, k;
      while (items_sent < 2000) begin
         steady_sender = ($urandom_range(0, 3) == 0);
         set_grid($urandom_range(1, 65535), $urandom_range(1, 65535),
                  $urandom_range(3, 16), $urandom_range(1, 8),
                  ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6),
                  $urandom_range(1, 25));
         write_reg(REG_SIG_MASK, $urandom_range(0, 1) ? 32'd0 : $urandom & $urandom & $urandom);
         write_reg(REG_BKG_MASK, $urandom_range(0, 1) ? 32'd0 : $urandom & $urandom & $urandom);
         send_command(ACT_CLEAR, 16'd0, 16'd0, 32'd0);
         for (int i = 0; i < 3; i++) begin
            hot_t[i] = pick_time();
            hot_p[i] = pick_phi();
         end
         n = $urandom_range(30, 80);
         for (int i = 0; i < n; i++) begin
            k = $urandom_range(0, 5);
            if (k < 3)
               send_command(ACT_ACCUM, hot_t[k], hot_p[k], pick_flags());
            else if (k == 5 && $urandom_range(0, 3) == 0)
               send_command(ACT_CLASSIFY, pick_time(), pick_phi(), $urandom);
            else
               send_command(ACT_ACCUM, pick_time(), pick_phi(), pick_flags());
         end
         drain_block();
         send_command(ACT_BUILD, 16'd0, 16'd0, 32'd0);
         n = $urandom_range(20, 50);
         for (int i = 0; i < n; i++) begin
            k = $urandom_range(0, 3);
            if (k < 3) send_command(ACT_CLASSIFY, hot_t[k], hot_p[k], $urandom);
            else       send_command(ACT_CLASSIFY, pick_time(), pick_phi(), $urandom);
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_action = ACT_CLEAR;
      req_hit_time = '0;
      req_hit_phi = '0;
      req_hit_flags = '0;
      csr_valid = 1'b0;
      csr_index = REG_TIME_SCALE;
      csr_wdata = '0;
      mismatch_count = 0;
      items_sent = 0;
      steady_sender = 1'b1;
      cfg_time_scale = 16'd205;
      cfg_phi_scale = 16'd63;
      cfg_num_time = 8'd128;
      cfg_num_phi = 7'd64;
      cfg_min_cell = 8'd3;
      cfg_min_sum = 12'd6;
      cfg_sig_mask = '0;
      cfg_bkg_mask = '0;
      clear_grid();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_defaults();
      test_masks();
      test_count_saturation();
      test_tiny_grids();
      test_random_events();

      drain_block();
      repeat (50) @(posedge clock);
      if (mismatch_count == 0 && pending_hits.size() == 0)
         $display("PASS time_phi_occupancy_prefilter");
      else
         $display("FAIL time_phi_occupancy_prefilter");
      $finish;
   end

endmodule
